@@ design/obhs_pkg.sv @@
// Shared types and codes for the order book half side.
// No dependencies; obhs_div, obhs_core and the top level import it.
`default_nettype none
package obhs_pkg;

  localparam int PRICE_W = 32;
  localparam int QTY_W   = 40;
  localparam int IN_QTY_W = 32;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_TRADE  = 2'd2;

  localparam logic [2:0] REG_SIDE    = 3'd0;
  localparam logic [2:0] REG_FLOOR   = 3'd1;
  localparam logic [2:0] REG_CEILING = 3'd2;
  localparam logic [2:0] REG_TICK    = 3'd3;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [PRICE_W-1:0]  price;
    logic [IN_QTY_W-1:0] quantity;
  } req_t;

  typedef struct packed {
    logic [2:0]         rank;
    logic               entry_valid;
    logic [PRICE_W-1:0] level_price;
    logic [QTY_W-1:0]   level_quantity;
    logic [QTY_W-1:0]   quantity_at_price;
    logic               rejected;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic               side;
    logic [PRICE_W-1:0] floor_price;
    logic [PRICE_W-1:0] ceiling_price;
    logic [PRICE_W-1:0] tick_size;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_UPD,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_INS1,
    ST_INS2,
    ST_UNLINK,
    ST_OUT_INIT,
    ST_OUT_RD,
    ST_OUT_DATA,
    ST_OUT_PRICE,
    ST_EMIT
  } st_t;

endpackage
`default_nettype wire

@@ design/obhs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module obhs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ design/obhs_div.sv @@
// Restoring divider, one quotient bit per cycle, for the price-to-level index.
// Depends on obhs_pkg for the price width.
`default_nettype none
module obhs_div
  import obhs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [PRICE_W-1:0] dividend,
  input  wire logic [PRICE_W-1:0] divisor,
  output logic                    done,
  output logic      [PRICE_W-1:0] quot,
  output logic      [PRICE_W-1:0] rem
);
  localparam int CW = $clog2(PRICE_W + 1);

  logic [CW-1:0]      cnt;
  logic               run;
  logic [PRICE_W-1:0] q;
  logic [PRICE_W-1:0] d;
  logic [PRICE_W-1:0] r;
  logic [PRICE_W:0]   trial;

  // partial remainder stays below the divisor, so it fits the price width
  assign trial = {r, q[PRICE_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(PRICE_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      d <= divisor;
      r <= '0;
    end else if (run) begin
      if (trial >= {1'b0, d}) begin
        r <= PRICE_W'(trial - {1'b0, d});
        q <= {q[PRICE_W-2:0], 1'b1};
      end else begin
        r <= trial[PRICE_W-1:0];
        q <= {q[PRICE_W-2:0], 1'b0};
      end
    end
  end

  assign quot = q;
  assign rem  = r;
endmodule
`default_nettype wire

@@ design/obhs_core.sv @@
// Book sequencer: level and link memories, list insertion walk, unlink and
// the rank-by-rank walk of the best levels. Uses obhs_pkg, obhs_ram, obhs_div.
`default_nettype none
module obhs_core
  import obhs_pkg::*;
#(
  parameter int LEVELS     = 1024,
  parameter int TOP_LEVELS = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic clear,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req_item,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp_item
);
  localparam int AW = $clog2(LEVELS);
  localparam int IW = $clog2(LEVELS + 2);
  localparam int RW = (TOP_LEVELS > 1) ? $clog2(TOP_LEVELS) : 1;
  localparam logic [IW-1:0] HEAD = IW'(LEVELS);
  localparam logic [IW-1:0] TAIL = IW'(LEVELS + 1);
  localparam logic [RW-1:0] RANK_LAST = RW'(TOP_LEVELS - 1);

  st_t state, state_next;

  // control registers
  logic [AW-1:0] clr;
  logic [IW-1:0] first;     // next link of head sentinel
  logic [IW-1:0] last_ptr;  // prev link of tail sentinel

  // payload registers
  logic [1:0]          cmd;
  logic [IN_QTY_W-1:0] qty;
  logic [AW-1:0]       idx;
  logic [IW-1:0]       p_ptr, a_ptr, cur, nxt;
  logic [RW-1:0]       rank;
  logic [QTY_W-1:0]    at_price;
  logic                rej;
  logic                out_ev;
  logic [PRICE_W-1:0]  out_price, prod;
  logic [QTY_W-1:0]    out_qty;

  // memories
  logic             lvl_we, nl_we, pl_we;
  logic [AW-1:0]    lvl_waddr, nl_waddr, pl_waddr, raddr;
  logic [QTY_W-1:0] lvl_wdata, lvl_rdata;
  logic [IW-1:0]    nl_wdata, pl_wdata, nl_rdata, pl_rdata;

  obhs_ram #(.WIDTH(QTY_W), .DEPTH(LEVELS)) u_level (
    .clk(clk), .we(lvl_we), .waddr(lvl_waddr), .wdata(lvl_wdata),
    .raddr(raddr), .rdata(lvl_rdata)
  );
  obhs_ram #(.WIDTH(IW), .DEPTH(LEVELS)) u_next (
    .clk(clk), .we(nl_we), .waddr(nl_waddr), .wdata(nl_wdata),
    .raddr(raddr), .rdata(nl_rdata)
  );
  obhs_ram #(.WIDTH(IW), .DEPTH(LEVELS)) u_prev (
    .clk(clk), .we(pl_we), .waddr(pl_waddr), .wdata(pl_wdata),
    .raddr(raddr), .rdata(pl_rdata)
  );

  // divider
  logic               div_start, div_done;
  logic [PRICE_W-1:0] div_quot, div_rem;

  obhs_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(req_item.price - cfg.floor_price), .divisor(cfg.tick_size),
    .done(div_done), .quot(div_quot), .rem(div_rem)
  );

  // shared decode
  logic             priced, bad_range, bad_div, best_ok, cur_ok, walk_more;
  logic [IW-1:0]    best, walk_n;
  logic [QTY_W:0]   sum;
  logic [QTY_W-1:0] add_val, red_val;
  logic             reduce_nop, reduce_all;
  logic [PRICE_W-1:0] prod_w;

  always_comb begin
    priced    = (req_item.cmd == CMD_ADD) || (req_item.cmd == CMD_CANCEL);
    bad_range = (cfg.tick_size == '0) || (req_item.price < cfg.floor_price) ||
                (req_item.price > cfg.ceiling_price);
    bad_div   = (div_rem != '0) || (div_quot >= PRICE_W'(LEVELS));
    best      = cfg.side ? last_ptr : first;
    best_ok   = best < IW'(LEVELS);
    cur_ok    = cur < IW'(LEVELS);
    walk_n    = (p_ptr == HEAD) ? first : nl_rdata;
    walk_more = (walk_n != TAIL) && (walk_n < IW'(idx));
    sum       = {1'b0, lvl_rdata} + (QTY_W + 1)'(qty);
    add_val   = sum[QTY_W] ? '1 : sum[QTY_W-1:0];
    reduce_nop = (lvl_rdata == '0) || (qty == '0);
    reduce_all = QTY_W'(qty) >= lvl_rdata;
    red_val   = reduce_all ? '0 : lvl_rdata - QTY_W'(qty);
    // level price wraps at the price width
    prod_w    = PRICE_W'(cur) * cfg.tick_size;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:    if (clr == AW'(LEVELS - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (req_valid) begin
          if (priced) begin
            state_next = bad_range ? ST_OUT_INIT : ST_DIV;
          end else if (req_item.cmd == CMD_TRADE && best_ok) begin
            state_next = ST_RD;
          end else begin
            state_next = ST_OUT_INIT;
          end
        end
      end
      ST_DIV:      if (div_done) state_next = bad_div ? ST_OUT_INIT : ST_RD;
      ST_RD:       state_next = ST_UPD;
      ST_UPD: begin
        if (cmd == CMD_ADD) begin
          if (qty != '0 && lvl_rdata == '0) state_next = ST_WALK_RD;
          else state_next = ST_OUT_INIT;
        end else begin
          if (!reduce_nop && reduce_all) state_next = ST_UNLINK;
          else state_next = ST_OUT_INIT;
        end
      end
      ST_WALK_RD:  state_next = ST_WALK_CHK;
      ST_WALK_CHK: state_next = walk_more ? ST_WALK_RD : ST_INS1;
      ST_INS1:     state_next = ST_INS2;
      ST_INS2:     state_next = ST_OUT_INIT;
      ST_UNLINK:   state_next = ST_OUT_INIT;
      ST_OUT_INIT: state_next = ST_OUT_RD;
      ST_OUT_RD:   state_next = cur_ok ? ST_OUT_DATA : ST_EMIT;
      ST_OUT_DATA: state_next = ST_OUT_PRICE;
      ST_OUT_PRICE: state_next = ST_EMIT;
      ST_EMIT:     if (!rsp_stall) state_next = (rank == RANK_LAST) ? ST_IDLE : ST_OUT_RD;
      default:     state_next = ST_CLEAR;
    endcase
  end

  // outputs and memory ports
  always_comb begin
    req_stall = (state != ST_IDLE);
    rsp_valid = (state == ST_EMIT);
    div_start = (state == ST_IDLE) && req_valid && priced && !bad_range;
    lvl_we = 1'b0; lvl_waddr = idx; lvl_wdata = '0;
    nl_we  = 1'b0; nl_waddr  = idx; nl_wdata  = a_ptr;
    pl_we  = 1'b0; pl_waddr  = idx; pl_wdata  = p_ptr;
    raddr  = idx;
    unique case (state)
      ST_CLEAR: begin
        lvl_we    = 1'b1;
        lvl_waddr = clr;
      end
      ST_UPD: begin
        if (cmd == CMD_ADD) begin
          lvl_we    = (qty != '0);
          lvl_wdata = add_val;
        end else begin
          lvl_we    = !reduce_nop;
          lvl_wdata = red_val;
        end
      end
      ST_WALK_RD: raddr = p_ptr[AW-1:0];
      ST_INS1: begin
        nl_we    = (p_ptr != HEAD);
        nl_waddr = p_ptr[AW-1:0];
        nl_wdata = IW'(idx);
        pl_we    = 1'b1;
      end
      ST_INS2: begin
        nl_we    = 1'b1;
        pl_we    = (a_ptr != TAIL);
        pl_waddr = a_ptr[AW-1:0];
        pl_wdata = IW'(idx);
      end
      ST_UNLINK: begin
        nl_we    = (p_ptr != HEAD);
        nl_waddr = p_ptr[AW-1:0];
        pl_we    = (a_ptr != TAIL);
        pl_waddr = a_ptr[AW-1:0];
      end
      ST_OUT_RD: raddr = cur[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      state    <= ST_CLEAR;
      clr      <= '0;
      first    <= TAIL;
      last_ptr <= HEAD;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr <= clr + 1'b1;
      if (state == ST_INS1 && p_ptr == HEAD) first <= IW'(idx);
      if (state == ST_INS2 && a_ptr == TAIL) last_ptr <= IW'(idx);
      if (state == ST_UNLINK) begin
        if (p_ptr == HEAD) first <= a_ptr;
        if (a_ptr == TAIL) last_ptr <= p_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cmd      <= req_item.cmd;
        qty      <= req_item.quantity;
        at_price <= '0;
        rej      <= priced && bad_range;
        idx      <= best[AW-1:0];
      end
      ST_DIV: begin
        if (div_done) begin
          rej <= bad_div;
          idx <= div_quot[AW-1:0];
        end
      end
      ST_UPD: begin
        p_ptr <= (cmd == CMD_ADD) ? HEAD : pl_rdata;
        a_ptr <= nl_rdata;
        if (cmd == CMD_ADD) begin
          at_price <= (qty != '0) ? add_val : lvl_rdata;
        end else if (cmd == CMD_CANCEL) begin
          at_price <= reduce_nop ? lvl_rdata : red_val;
        end
      end
      ST_WALK_CHK: begin
        if (walk_more) p_ptr <= walk_n;
        else a_ptr <= walk_n;
      end
      ST_OUT_INIT: begin
        cur  <= best;
        rank <= '0;
      end
      ST_OUT_RD: begin
        if (!cur_ok) begin
          out_ev    <= 1'b0;
          out_price <= '0;
          out_qty   <= '0;
          nxt       <= cur;
        end
      end
      ST_OUT_DATA: begin
        out_qty <= lvl_rdata;
        nxt     <= cfg.side ? pl_rdata : nl_rdata;
        prod    <= prod_w;
      end
      ST_OUT_PRICE: begin
        out_price <= cfg.floor_price + prod;
        out_ev    <= 1'b1;
      end
      ST_EMIT: begin
        if (!rsp_stall && rank != RANK_LAST) begin
          rank <= rank + 1'b1;
          cur  <= nxt;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    rsp_item.rank              = 3'(rank);
    rsp_item.entry_valid       = out_ev;
    rsp_item.level_price       = out_price;
    rsp_item.level_quantity    = out_qty;
    rsp_item.quantity_at_price = at_price;
    rsp_item.rejected          = rej;
    rsp_item.last              = (rank == RANK_LAST);
  end
endmodule
`default_nettype wire

@@ design/order_book_half_side_top_n_top.sv @@
// Top level of the order book half side: configuration registers and core.
// Uses obhs_pkg and obhs_core.
//
// Usage: items (cmd, price, quantity) enter on req_valid/req_stall; every
// item answers with TOP_LEVELS result items on rsp_valid/rsp_stall, best
// rank first, the final one flagged by last. Configuration writes go in on
// cfg_valid/cfg_ready (always ready); a write to a listed register also
// empties the book.
// Steps per item: add and cancel check the price in a 32-step serial
// divider; then one memory read/modify/write pass; for an add
// to an empty level a list walk over every occupied lower level; then
// a read of each rank, with a data and a price step for an occupied
// one, and the emit, held while the receiver holds rsp_stall. The next
// item is taken once the last rank is accepted.
// Reset and every clearing register write start a clearing pass over
// every entry of the level memory; req_stall stays high meanwhile. A
// stalled result holds its value until taken.
`default_nettype none
module order_book_half_side_top_n_top
  import obhs_pkg::*;
#(
  parameter int LEVELS     = 1024,
  parameter int TOP_LEVELS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire req_t               req_item,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output rsp_t                    rsp_item,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [PRICE_W-1:0] cfg_data
);
  cfg_t cfg;
  logic clear;

  assign cfg_ready = 1'b1;

  always_comb begin
    clear = 1'b0;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SIDE, REG_FLOOR, REG_CEILING, REG_TICK: clear = 1'b1;
        default: clear = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.side          <= 1'b0;
      cfg.floor_price   <= '0;
      cfg.ceiling_price <= PRICE_W'(1023);
      cfg.tick_size     <= PRICE_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SIDE:    cfg.side          <= cfg_data[0];
        REG_FLOOR:   cfg.floor_price   <= cfg_data;
        REG_CEILING: cfg.ceiling_price <= cfg_data;
        REG_TICK:    cfg.tick_size     <= cfg_data;
        default: ;
      endcase
    end
  end

  obhs_core #(.LEVELS(LEVELS), .TOP_LEVELS(TOP_LEVELS)) u_core (
    .clk(clk), .rst(rst), .cfg(cfg), .clear(clear),
    .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item)
  );
endmodule
`default_nettype wire
